/* rtl/pbb_pkg.sv */
// Shared types and constants for the page bitmap blitter.
// Used by every module of the block; depends on nothing.
package pbb_pkg;

  localparam int SCREEN_WIDTH_DEF = 128;
  localparam int FRAME_BYTES_DEF  = 1024;

  localparam int COORD_W = 10;
  localparam int SIZE_W  = 8;
  localparam int BYTE_W  = 8;
  localparam int RA_W    = 10;

  localparam logic KIND_BLIT = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // Register indexes; register i sits at byte address 4*i.
  typedef enum logic [2:0] {
    REG_DEST_X,
    REG_DEST_Y,
    REG_WIDTH,
    REG_HEIGHT,
    REG_MIRROR,
    REG_DRAW_MODE
  } reg_idx_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] dest_x;
    logic signed [COORD_W-1:0] dest_y;
    logic [SIZE_W-1:0]         image_width;
    logic [SIZE_W-1:0]         image_height;
    logic                      mirror;
    logic                      draw_mode;
  } cfg_t;

  // Control of one request on its way to the frame store banks.
  typedef struct packed {
    logic                   vld;
    logic                   is_read;
    logic                   rd_zero;
    logic                   rd_bank;
    logic                   mode;
    logic [1:0]             wen;
    logic [1:0][BYTE_W-1:0] bits;
  } a_ctl_t;

endpackage

/* rtl/pbb_cfg.sv */
// APB-style register file holding the blit placement and mode settings.
// Depends on pbb_pkg for the cfg_t layout and the register indexes.
module pbb_cfg import pbb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr;

  assign idx    = reg_idx_e'(paddr[4:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      unique case (idx)
        REG_DEST_X:    cfg_d.dest_x       = pwdata[COORD_W-1:0];
        REG_DEST_Y:    cfg_d.dest_y       = pwdata[COORD_W-1:0];
        REG_WIDTH:     cfg_d.image_width  = pwdata[SIZE_W-1:0];
        REG_HEIGHT:    cfg_d.image_height = pwdata[SIZE_W-1:0];
        REG_MIRROR:    cfg_d.mirror       = pwdata[0];
        REG_DRAW_MODE: cfg_d.draw_mode    = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_DEST_X:    prdata = 32'(cfg_q.dest_x);
      REG_DEST_Y:    prdata = 32'(cfg_q.dest_y);
      REG_WIDTH:     prdata = 32'(cfg_q.image_width);
      REG_HEIGHT:    prdata = 32'(cfg_q.image_height);
      REG_MIRROR:    prdata = 32'(cfg_q.mirror);
      REG_DRAW_MODE: prdata = 32'(cfg_q.draw_mode);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dest_x       <= '0;
      cfg_q.dest_y       <= '0;
      cfg_q.image_width  <= SIZE_W'(8);
      cfg_q.image_height <= SIZE_W'(8);
      cfg_q.mirror       <= 1'b0;
      cfg_q.draw_mode    <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

/* rtl/pbb_bank.sv */
// One bank of the frame store: a byte-wide synchronous RAM with one write
// port and one registered read port. Depends on pbb_pkg for defaults.
module pbb_bank import pbb_pkg::*; #(
  parameter int DEPTH = FRAME_BYTES_DEF / 2
) (
  input  logic                     clk_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [BYTE_W-1:0]        wdata_i,
  output logic [BYTE_W-1:0]        rdata_o
);

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rdata_q;

  assign rdata_o = rdata_q;

  // A read and a write of the same entry in one cycle return the old byte.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

endmodule

/* rtl/pbb_addr.sv */
// Request front end: bitmap position counters, placement and clipping, and
// bank address generation for blits and reads. Depends on pbb_pkg.
module pbb_addr import pbb_pkg::*; #(
  parameter int SCREEN_WIDTH = SCREEN_WIDTH_DEF,
  parameter int FRAME_BYTES  = FRAME_BYTES_DEF,
  localparam int PAGE_ROWS   = FRAME_BYTES / SCREEN_WIDTH,
  localparam int BANK_ROWS   = (PAGE_ROWS > 1) ? (PAGE_ROWS + 1) / 2 : 1,
  localparam int BANK_DEPTH  = BANK_ROWS * SCREEN_WIDTH,
  localparam int BA_W        = $clog2(BANK_DEPTH)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  logic                      acc_i,
  input  logic                      kind_i,
  input  logic                      sof_i,
  input  logic [BYTE_W-1:0]         image_byte_i,
  input  logic [RA_W-1:0]           read_address_i,
  input  cfg_t                      cfg_i,
  output a_ctl_t                    ctl_o,
  output logic [1:0][BA_W-1:0]      raddr_o
);

  localparam int XW       = COORD_W + 1;
  localparam int PG_W     = XW - 3;
  localparam int SW_LOG   = $clog2(SCREEN_WIDTH);
  localparam int RECIP_SH = RA_W + SW_LOG;
  localparam int RECIP    = ((2 ** RECIP_SH) + SCREEN_WIDTH - 1) / SCREEN_WIDTH;
  localparam int RECIP_W  = RA_W + 2;
  localparam int PROD_W   = RA_W + RECIP_W;
  localparam int RP_W     = $clog2(((2 ** RA_W) - 1) / SCREEN_WIDTH + 1);

  logic [SIZE_W-1:0]        col_cnt_q, col_cnt_d, u;
  logic [5:0]               page_cnt_q, page_cnt_d, pv, pages;
  logic                     active, off, last_col;
  logic signed [XW-1:0]     xs, ys, span_x, span_y, col, row;
  logic [PROD_W-1:0]        prod;
  logic [RP_W-1:0]          rpage;

  logic                     a_vld_q, a_read_q, a_draw_q, a_mode_q;
  logic signed [XW-1:0]     a_col_q;
  logic signed [PG_W-1:0]   a_pg_q;
  logic [2:0]               a_shift_q;
  logic [BYTE_W-1:0]        a_byte_q;
  logic [RA_W-1:0]          a_addr_q;
  logic [RP_W-1:0]          a_rpage_q;

  logic [2*BYTE_W-1:0]      spread;
  logic                     col_ok, rd_ok, lo_here;
  logic signed [PG_W-1:0]   q;
  int                       rd_local;

  // Placement of the incoming byte and counter update.
  always_comb begin
    u        = sof_i ? '0 : col_cnt_q;
    pv       = sof_i ? '0 : page_cnt_q;
    pages    = 6'((9'(cfg_i.image_height) + 9'd7) >> 3);
    active   = (cfg_i.image_width != '0) && (cfg_i.image_height != '0) && (pv < pages);
    xs       = XW'(cfg_i.dest_x);
    ys       = XW'(cfg_i.dest_y);
    span_x   = xs + $signed(XW'(cfg_i.image_width));
    span_y   = ys + $signed(XW'(cfg_i.image_height));
    off      = (span_x <= 0) || (span_y <= 0) ||
               (int'(cfg_i.dest_x) >= SCREEN_WIDTH) ||
               (int'(cfg_i.dest_y) >= PAGE_ROWS * 8);
    if (cfg_i.mirror) begin
      col = span_x - $signed(XW'(u)) - $signed(XW'(1));
    end else begin
      col = xs + $signed(XW'(u));
    end
    row      = ys + $signed(XW'({pv, 3'b000}));
    last_col = (9'(u) + 9'd1) >= 9'(cfg_i.image_width);

    col_cnt_d  = col_cnt_q;
    page_cnt_d = page_cnt_q;
    if (acc_i && kind_i == KIND_BLIT) begin
      col_cnt_d  = u;
      page_cnt_d = pv;
      if (active) begin
        if (last_col) begin
          col_cnt_d  = '0;
          page_cnt_d = pv + 6'd1;
        end else begin
          col_cnt_d  = u + SIZE_W'(1);
        end
      end
    end

    // Page of a read address by reciprocal multiplication.
    prod  = PROD_W'(read_address_i) * PROD_W'(RECIP);
    rpage = prod[RECIP_SH +: RP_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q  <= '0;
      page_cnt_q <= '0;
      a_vld_q    <= 1'b0;
      a_read_q   <= 1'b0;
      a_draw_q   <= 1'b0;
    end else begin
      col_cnt_q  <= col_cnt_d;
      page_cnt_q <= page_cnt_d;
      if (adv_i) begin
        a_vld_q  <= acc_i;
        a_read_q <= kind_i == KIND_READ;
        a_draw_q <= active && !off;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      a_col_q   <= col;
      a_pg_q    <= row[XW-1:3];
      a_shift_q <= row[2:0];
      a_byte_q  <= image_byte_i;
      a_mode_q  <= cfg_i.draw_mode;
      a_addr_q  <= read_address_i;
      a_rpage_q <= rpage;
    end
  end

  // Each bank holds pages of one parity, so a byte split over two pages
  // touches each bank at most once.
  always_comb begin
    spread   = (2*BYTE_W)'(a_byte_q) << a_shift_q;
    col_ok   = !a_col_q[XW-1] && (int'(a_col_q) < SCREEN_WIDTH);
    rd_ok    = (int'(a_rpage_q) < PAGE_ROWS) && (int'(a_addr_q) < FRAME_BYTES);
    rd_local = int'(a_addr_q) - ((int'(a_rpage_q) + 1) >> 1) * SCREEN_WIDTH;

    ctl_o.vld     = a_vld_q;
    ctl_o.is_read = a_read_q;
    ctl_o.rd_zero = !rd_ok;
    ctl_o.rd_bank = a_rpage_q[0];
    ctl_o.mode    = a_mode_q;
    lo_here       = 1'b0;
    q             = '0;
    for (int b = 0; b < 2; b++) begin
      lo_here = a_pg_q[0] == 1'(b);
      q       = lo_here ? a_pg_q : a_pg_q + $signed(PG_W'(1));
      ctl_o.wen[b]  = a_vld_q && !a_read_q && a_draw_q && col_ok &&
                      !q[PG_W-1] && (int'(q) < PAGE_ROWS) &&
                      (lo_here || a_shift_q != 3'd0);
      ctl_o.bits[b] = lo_here ? spread[BYTE_W-1:0] : spread[2*BYTE_W-1:BYTE_W];
      raddr_o[b]    = a_read_q ? BA_W'(rd_local)
                               : BA_W'(int'(q[PG_W-1:1]) * SCREEN_WIDTH + int'(a_col_q));
    end
  end

  // A page counter never runs past the largest page count of an image.
  a_page_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    page_cnt_q <= 6'd32)
    else $error("page counter beyond the largest image");

endmodule

/* rtl/page_bitmap_blitter.sv */
// Page bitmap blitter: 1-bit-per-pixel page framebuffer with a byte blit stream.
// A read passes the address stage and the bank read; its byte is then registered
// to read_byte_o. A blit byte is merged into the store by the read-modify-write
// stage. Throughput: one request per cycle while in_stall_o is low, set by the
// single read and write port of each page-parity bank. After reset a clearing
// pass zeroes the store one entry per bank per cycle, with in_stall_o high throughout.
module page_bitmap_blitter import pbb_pkg::*; #(
  parameter int SCREEN_WIDTH = SCREEN_WIDTH_DEF,
  parameter int FRAME_BYTES  = FRAME_BYTES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              kind_i,
  input  logic              start_of_image_i,
  input  logic [BYTE_W-1:0] image_byte_i,
  input  logic [RA_W-1:0]   read_address_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [BYTE_W-1:0] read_byte_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int PAGE_ROWS  = FRAME_BYTES / SCREEN_WIDTH;
  localparam int BANK_ROWS  = (PAGE_ROWS > 1) ? (PAGE_ROWS + 1) / 2 : 1;
  localparam int BANK_DEPTH = BANK_ROWS * SCREEN_WIDTH;
  localparam int BA_W       = $clog2(BANK_DEPTH);

  cfg_t                    cfg;
  a_ctl_t                  a_ctl, b_ctl_q;
  logic [1:0][BA_W-1:0]    a_raddr, b_addr_q, bank_waddr;
  logic [1:0]              bank_we, fwd_q, fwd_d;
  logic [1:0][BYTE_W-1:0]  bank_wdata, bank_rdata, fwd_data_q, merged_rd;
  logic                    clearing_q;
  logic [BA_W-1:0]         clr_q;
  logic                    out_valid_q;
  logic [BYTE_W-1:0]       read_byte_q;
  logic                    adv, acc;

  assign adv         = !(out_valid_q && out_stall_i);
  assign in_stall_o  = clearing_q || !adv;
  assign acc         = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign read_byte_o = read_byte_q;

  pbb_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pbb_addr #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .FRAME_BYTES  (FRAME_BYTES)
  ) u_addr (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .adv_i          (adv),
    .acc_i          (acc),
    .kind_i         (kind_i),
    .sof_i          (start_of_image_i),
    .image_byte_i   (image_byte_i),
    .read_address_i (read_address_i),
    .cfg_i          (cfg),
    .ctl_o          (a_ctl),
    .raddr_o        (a_raddr)
  );

  for (genvar g = 0; g < 2; g++) begin : g_bank
    pbb_bank #(
      .DEPTH (BANK_DEPTH)
    ) u_bank (
      .clk_i   (clk_i),
      .re_i    (adv),
      .raddr_i (a_raddr[g]),
      .we_i    (bank_we[g]),
      .waddr_i (bank_waddr[g]),
      .wdata_i (bank_wdata[g]),
      .rdata_o (bank_rdata[g])
    );
  end

  // Read-modify-write stage. A byte written in the cycle its entry was read
  // is taken from the forwarding register instead of the stale RAM output.
  always_comb begin
    for (int b = 0; b < 2; b++) begin
      merged_rd[b] = fwd_q[b] ? fwd_data_q[b] : bank_rdata[b];
      if (clearing_q) begin
        bank_we[b]    = 1'b1;
        bank_waddr[b] = clr_q;
        bank_wdata[b] = '0;
      end else begin
        bank_we[b]    = adv && b_ctl_q.vld && b_ctl_q.wen[b];
        bank_waddr[b] = b_addr_q[b];
        bank_wdata[b] = b_ctl_q.mode ? (merged_rd[b] & ~b_ctl_q.bits[b])
                                     : (merged_rd[b] | b_ctl_q.bits[b]);
      end
      fwd_d[b] = bank_we[b] && (bank_waddr[b] == a_raddr[b]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q  <= 1'b1;
      clr_q       <= '0;
      b_ctl_q     <= '0;
      fwd_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (clearing_q) begin
        if (clr_q == BA_W'(BANK_DEPTH - 1)) begin
          clearing_q <= 1'b0;
        end
        clr_q <= clr_q + BA_W'(1);
      end
      if (adv) begin
        b_ctl_q     <= a_ctl;
        fwd_q       <= fwd_d;
        out_valid_q <= b_ctl_q.vld && b_ctl_q.is_read;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_addr_q   <= a_raddr;
      fwd_data_q <= bank_wdata;
      if (b_ctl_q.vld && b_ctl_q.is_read) begin
        read_byte_q <= b_ctl_q.rd_zero ? '0 : merged_rd[b_ctl_q.rd_bank];
      end
    end
  end

  // The pipeline stays empty while the store is being cleared.
  a_empty_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> !b_ctl_q.vld)
    else $error("request in flight during clearing pass");

  // A result appears only from a read request leaving the store stage.
  a_out_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(b_ctl_q.vld && b_ctl_q.is_read))
    else $error("result without a read request");

  // While the output holds a stalled result, the store is not modified.
  a_no_write_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i && !clearing_q) |-> (bank_we == 2'b00))
    else $error("store written while the pipeline is stalled");

  // Forwarding only ever follows a write to that bank.
  a_fwd_after_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(fwd_q[0] || fwd_q[1]) |-> $past(bank_we != 2'b00))
    else $error("forwarding without a preceding write");

endmodule
